// ----- hdl/srfr_pkg.sv -----
`default_nettype none

package srfr_pkg;

   // Result status codes carried in the low bits of rsp_tuser.
   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_CONSUMED = 3'd1,
      ST_OK       = 3'd2,
      ST_CSUM     = 3'd3,
      ST_FORMAT   = 3'd4,
      ST_BUSY     = 3'd5
   } status_type;

   // Request operation codes carried in req_tuser.
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_ARM   = 2'd1,
      OP_ABORT = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Frame framing constants.
   localparam logic [7:0] HDR1_BYTE    = 8'hAA;
   localparam logic [7:0] HDR2_BYTE    = 8'h55;
   localparam logic [7:0] GOOD_LENGTH  = 8'h10;
   localparam logic [7:0] ADDR_RESET   = 8'h01;
   localparam logic [8:0] FRAME_EXTRA  = 9'd5;
   localparam int         PAYLOAD_KEEP = 16;
   localparam int         WORD_COUNT   = 4;

endpackage

`default_nettype wire

// ----- hdl/sensor_response_frame_receiver_unit.sv -----
// Sensor response frame receiver.
// Requests arrive on req_tvalid/req_tready: req_tuser holds the operation
// (received byte, arm, abort) and req_tdata the received byte. Each request
// gives exactly one result on rsp_tvalid/rsp_tready: rsp_tuser holds the
// status and the data-valid flag, rsp_tdata the four held sensor words.
// A frame is AA 55, address, length, payload, XOR checksum; bytes count only
// while the receiver is armed, and a completed or aborted frame disarms it.
// The per-byte parse is one level of logic between the request and the
// result register: a result appears in the cycle after its request is taken,
// and one request is taken in every cycle while the result side keeps up.
// When the result side stalls, the pending result is held and req_tready
// drops until that result is taken; no request is lost.
// Reset clears the receive state, held words and valid flag, sets the device
// address to 1 and empties the result register. The user writes the device
// address via csr_wr_en/csr_wr_data only while the block is idle, unenforced.
`default_nettype none

module sensor_response_frame_receiver_unit #(
   parameter int BUFFER_BYTES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,   // device_address
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,     // op
   input  wire logic [7:0]   req_tdata,     // rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [3:0]        rsp_tuser,     // status [2:0], data_valid [3]
   output logic [127:0]      rsp_tdata      // up, left, down, right from bit 0
);
   import srfr_pkg::*;

   localparam int CntW = $clog2(BUFFER_BYTES + 1);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_HDR2 = 3'd1,
      PH_ADDR = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   logic [7:0]      addr_ff;
   logic            awaiting_ff, awaiting_in;
   phase_type       phase_ff, phase_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [7:0]      length_ff, length_in;
   logic [7:0]      xor_ff, xor_in;
   logic [7:0]      payload_ff [PAYLOAD_KEEP];
   logic [31:0]     held_ff [WORD_COUNT];
   logic [31:0]     held_in [WORD_COUNT];
   logic            held_we;
   logic            valid_ff, valid_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff;

   logic            req_take;
   op_type          op;
   logic [7:0]      rx_byte;
   logic [CntW-1:0] count_inc;
   logic [CntW-1:0] pos;
   logic [8:0]      len_total;
   logic [8:0]      frame_total;
   logic            pay_we;

   // A new request is taken whenever the result register is free or drains.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign rx_byte    = req_tdata;

   assign count_inc   = count_ff + CntW'(1);
   assign pos         = count_inc - CntW'(5);
   assign len_total   = FRAME_EXTRA + {1'b0, rx_byte};
   assign frame_total = FRAME_EXTRA + {1'b0, length_ff};

   // Assemble the little-endian words from the payload buffer.
   always_comb begin
      for (int k = 0; k < WORD_COUNT; k++) begin
         held_in[k] = {payload_ff[4*k+3], payload_ff[4*k+2],
                       payload_ff[4*k+1], payload_ff[4*k]};
      end
   end

   // Next state of the receiver for the request at the input.
   always_comb begin
      awaiting_in = awaiting_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      xor_in      = xor_ff;
      valid_in    = valid_ff;
      status_in   = ST_IGNORED;
      held_we     = 1'b0;
      pay_we      = 1'b0;
      case (op)
         OP_BYTE: begin
            if (awaiting_ff) begin
               status_in = ST_CONSUMED;
               case (phase_ff)
                  PH_HDR2: begin
                     if (rx_byte == HDR2_BYTE) begin
                        phase_in = PH_ADDR;
                        count_in = CntW'(2);
                     end else begin
                        phase_in  = PH_HUNT;
                        count_in  = '0;
                        length_in = '0;
                        xor_in    = '0;
                        status_in = ST_IGNORED;
                     end
                  end
                  PH_ADDR: begin
                     if (rx_byte == addr_ff) begin
                        phase_in = PH_LEN;
                        count_in = CntW'(3);
                        xor_in   = rx_byte;
                     end else begin
                        phase_in  = PH_HUNT;
                        count_in  = '0;
                        length_in = '0;
                        xor_in    = '0;
                        status_in = ST_IGNORED;
                     end
                  end
                  PH_LEN: begin
                     if (len_total <= 9'(BUFFER_BYTES)) begin
                        length_in = rx_byte;
                        xor_in    = xor_ff ^ rx_byte;
                        count_in  = CntW'(4);
                        phase_in  = PH_DATA;
                     end else begin
                        phase_in  = PH_HUNT;
                        count_in  = '0;
                        length_in = '0;
                        xor_in    = '0;
                        status_in = ST_IGNORED;
                     end
                  end
                  PH_DATA: begin
                     if (9'(count_inc) >= frame_total) begin
                        // Checksum byte: judge the frame and disarm.
                        if (length_ff != GOOD_LENGTH) begin
                           valid_in  = 1'b0;
                           status_in = ST_FORMAT;
                        end else if (xor_ff != rx_byte) begin
                           valid_in  = 1'b0;
                           status_in = ST_CSUM;
                        end else begin
                           held_we   = 1'b1;
                           valid_in  = 1'b1;
                           status_in = ST_OK;
                        end
                        awaiting_in = 1'b0;
                        phase_in    = PH_HUNT;
                        count_in    = '0;
                        length_in   = '0;
                        xor_in      = '0;
                     end else begin
                        count_in = count_inc;
                        xor_in   = xor_ff ^ rx_byte;
                        pay_we   = (pos < CntW'(PAYLOAD_KEEP));
                     end
                  end
                  default: begin
                     if (rx_byte == HDR1_BYTE) begin
                        phase_in = PH_HDR2;
                        count_in = CntW'(1);
                     end else begin
                        phase_in  = PH_HUNT;
                        status_in = ST_IGNORED;
                     end
                  end
               endcase
            end
         end
         OP_ARM: begin
            if (awaiting_ff) begin
               status_in = ST_BUSY;
            end else begin
               awaiting_in = 1'b1;
               phase_in    = PH_HUNT;
               count_in    = '0;
               length_in   = '0;
               xor_in      = '0;
               status_in   = ST_CONSUMED;
            end
         end
         OP_ABORT: begin
            awaiting_in = 1'b0;
            phase_in    = PH_HUNT;
            count_in    = '0;
            length_in   = '0;
            xor_in      = '0;
            status_in   = ST_CONSUMED;
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   // Receiver state, held words and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= ADDR_RESET;
         awaiting_ff  <= 1'b0;
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         length_ff    <= '0;
         xor_ff       <= '0;
         valid_ff     <= 1'b0;
         status_ff    <= ST_IGNORED;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WORD_COUNT; k++) begin
            held_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            addr_ff <= csr_wr_data;
         end
         if (req_take) begin
            awaiting_ff <= awaiting_in;
            phase_ff    <= phase_in;
            count_ff    <= count_in;
            length_ff   <= length_in;
            xor_ff      <= xor_in;
            valid_ff    <= valid_in;
            status_ff   <= status_in;
            if (held_we) begin
               for (int k = 0; k < WORD_COUNT; k++) begin
                  held_ff[k] <= held_in[k];
               end
            end
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload buffer, written one byte at a time.
   always_ff @(posedge clock) begin
      if (req_take && pay_we) begin
         payload_ff[pos[3:0]] <= rx_byte;
      end
   end

   // Held words and the valid flag only change when the pending result drains,
   // so the result reads them directly.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {valid_ff, status_ff};
   assign rsp_tdata  = {held_ff[3], held_ff[2], held_ff[1], held_ff[0]};

   // A good frame always leaves the valid flag set.
   a_ok_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OK) |-> valid_ff)
      else $error("frame ok reported without valid flag");

   // A failed frame always leaves the valid flag clear.
   a_err_clears_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_CSUM || status_ff == ST_FORMAT)) |-> !valid_ff)
      else $error("frame error reported with valid flag set");

   // The parser only leaves the hunting phase while armed.
   a_phase_armed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HUNT) |-> awaiting_ff)
      else $error("receive phase advanced while not armed");

   // Arming an idle receiver takes effect on the next cycle.
   a_arm_takes: assert property (@(posedge clock) disable iff (reset)
      (req_take && op == OP_ARM && !awaiting_ff) |=> awaiting_ff)
      else $error("arm request did not arm the receiver");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
   import srfr_pkg::*;

   localparam int FRAME_BUFFER = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 125;

   // Receive phases of the frame parser, as tracked by the predictor.
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_HDR2 = 3'd1,
      PH_ADDR = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4
   } rx_phase_type;

   // One result as it should appear on the response channel.
   typedef struct packed {
      status_type        status;
      logic              valid;
      logic [3:0][31:0]  words;
   } sensor_reply_type;

   // Predicts the receiver response for every accepted request and checks
   // the responses against those predictions in order.
   class frame_scoreboard;
      logic [7:0]       dev_addr;
      bit               armed;
      rx_phase_type     phase;
      int               byte_count;
      logic [7:0]       frame_len;
      logic [7:0]       xor_sum;
      logic [7:0]       payload [16];
      logic [3:0][31:0] held_words;
      bit               held_valid;
      sensor_reply_type expected_replies [$];
      int               errors;
      int               counted;

      function new();
         dev_addr   = ADDR_RESET;
         armed      = 1'b0;
         held_words = '0;
         held_valid = 1'b0;
         errors     = 0;
         counted    = 0;
         foreach (payload[i]) payload[i] = 8'h00;
         clear_rx();
      endfunction

      function void clear_rx();
         phase      = PH_HUNT;
         byte_count = 0;
         frame_len  = 8'h00;
         xor_sum    = 8'h00;
      endfunction

      // Advances the frame parser by one received byte while armed.
      function status_type parse_byte(logic [7:0] b);
         status_type st;
         int total;
         int pos;
         st = ST_CONSUMED;
         case (phase)
            PH_HDR2: begin
               if (b == HDR2_BYTE) begin
                  phase      = PH_ADDR;
                  byte_count = 2;
               end else begin
                  clear_rx();
                  st = ST_IGNORED;
               end
            end
            PH_ADDR: begin
               if (b == dev_addr) begin
                  phase      = PH_LEN;
                  byte_count = 3;
                  xor_sum    = b;
               end else begin
                  clear_rx();
                  st = ST_IGNORED;
               end
            end
            PH_LEN: begin
               // A length that cannot fit the buffer drops the frame.
               if (5 + int'(b) <= FRAME_BUFFER) begin
                  frame_len  = b;
                  xor_sum    = xor_sum ^ b;
                  byte_count = 4;
                  phase      = PH_DATA;
               end else begin
                  clear_rx();
                  st = ST_IGNORED;
               end
            end
            PH_DATA: begin
               total      = 5 + int'(frame_len);
               byte_count = byte_count + 1;
               if (byte_count >= total) begin
                  // The last byte is the checksum and completes the frame.
                  if (frame_len != GOOD_LENGTH) begin
                     held_valid = 1'b0;
                     st = ST_FORMAT;
                  end else if (xor_sum != b) begin
                     held_valid = 1'b0;
                     st = ST_CSUM;
                  end else begin
                     for (int k = 0; k < 4; k++)
                        held_words[k] = {payload[4*k+3], payload[4*k+2],
                                         payload[4*k+1], payload[4*k]};
                     held_valid = 1'b1;
                     st = ST_OK;
                  end
                  armed = 1'b0;
                  clear_rx();
               end else begin
                  pos = byte_count - 5;
                  if (pos < 16)
                     payload[pos] = b;
                  xor_sum = xor_sum ^ b;
               end
            end
            default: begin
               if (b == HDR1_BYTE) begin
                  phase      = PH_HDR2;
                  byte_count = 1;
               end else begin
                  phase = PH_HUNT;
                  st = ST_IGNORED;
               end
            end
         endcase
         return st;
      endfunction

      // Works out the response to one accepted request and queues it.
      function void note_request(op_type op, logic [7:0] b);
         sensor_reply_type r;
         case (op)
            OP_BYTE: r.status = armed ? parse_byte(b) : ST_IGNORED;
            OP_ARM: begin
               if (armed) begin
                  r.status = ST_BUSY;
               end else begin
                  clear_rx();
                  armed = 1'b1;
                  r.status = ST_CONSUMED;
               end
            end
            OP_ABORT: begin
               armed = 1'b0;
               clear_rx();
               r.status = ST_CONSUMED;
            end
            default: r.status = ST_IGNORED;
         endcase
         r.valid = held_valid;
         r.words = held_words;
         expected_replies.push_back(r);
         if (r.status != ST_IGNORED)
            counted++;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Compares one accepted response with the oldest prediction.
      task check_response(logic [3:0] tuser, logic [127:0] tdata);
         sensor_reply_type want;
         string names [4];
         names = '{"up", "left", "down", "right"};
         if (expected_replies.size() == 0) begin
            report("response arrived with no request outstanding");
         end else begin
            want = expected_replies.pop_front();
            if (tuser[2:0] !== want.status)
               report($sformatf("status got %0d want %0d", tuser[2:0], want.status));
            if (tuser[3] !== want.valid)
               report($sformatf("data_valid got %0b want %0b", tuser[3], want.valid));
            for (int k = 0; k < 4; k++)
               if (tdata[32*k +: 32] !== want.words[k])
                  report($sformatf("%s word got %h want %h", names[k],
                                   tdata[32*k +: 32], want.words[k]));
         end
      endtask

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;     // op
   logic [7:0]   req_tdata;     // rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [3:0]   rsp_tuser;     // status [2:0], data_valid [3]
   logic [127:0] rsp_tdata;     // up, left, down, right from bit 0

   frame_scoreboard sb;
   bit              send_calm;
   int              cycles = 0;

   sensor_response_frame_receiver_unit #(
      .BUFFER_BYTES(FRAME_BUFFER)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   // Free-running clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle lengths: mostly none, often short, now and then long.
   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Watch both channels, predict on every accepted request and check
   // every accepted response; also enforce the overall cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata);
      end
   end

   // The response side alternates runs of ready with random stalls.
   initial begin
      int  run;
      bit  calm;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         calm = ($urandom_range(0, 7) == 0);
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 20);
         repeat (run - 1) @(negedge clock);
         run = pick_gap(calm);
         if (run > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   // Offers one request after an optional gap and waits until it is taken.
   // Entered and left at a falling edge.
   task automatic send_request(input op_type op, input logic [7:0] b);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(OP_BYTE, b);
   endtask

   // Waits for every outstanding response, then writes the device address.
   task automatic write_address(input logic [7:0] addr);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.dev_addr = addr;
   endtask

   // Sends one frame. The address or second header byte can be broken, the
   // checksum corrupted, and the frame cut short by an abort after cut bytes.
   task automatic send_frame(input logic [7:0] len, input bit bad_sum,
                             input bit bad_hdr, input bit bad_addr, input int cut);
      logic [7:0] bytes [$];
      logic [7:0] sum;
      logic [7:0] addr;
      logic [7:0] d;
      int         fill;
      fill = $urandom_range(0, 9);
      addr = bad_addr ? sb.dev_addr ^ 8'($urandom_range(1, 255)) : sb.dev_addr;
      bytes.push_back(HDR1_BYTE);
      bytes.push_back(bad_hdr ? HDR2_BYTE ^ 8'($urandom_range(1, 255)) : HDR2_BYTE);
      bytes.push_back(addr);
      bytes.push_back(len);
      sum = addr ^ len;
      for (int i = 0; i < int'(len); i++) begin
         // Occasionally the payload is all zeros or all ones.
         d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
         bytes.push_back(d);
         sum = sum ^ d;
      end
      bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
      foreach (bytes[i]) begin
         if (cut >= 0 && i >= cut)
            break;
         send_byte(bytes[i]);
      end
      if (cut >= 0)
         send_request(OP_ABORT, 8'($urandom));
   endtask

   // Short hand-picked sequence covering each special case once.
   task automatic run_directed();
      // Byte while disarmed and the undefined operation are both ignored.
      send_byte(8'h00);
      send_request(OP_NONE, 8'hFF);
      // Arm, a refused second arm, abort, abort while idle, arm again.
      send_request(OP_ARM, 8'hFF);
      send_request(OP_ARM, 8'h00);
      send_request(OP_ABORT, 8'hFF);
      send_request(OP_ABORT, 8'h00);
      send_request(OP_ARM, 8'h00);
      // A byte other than the first header byte while hunting.
      send_byte(8'h00);
      // Wrong second header byte.
      send_byte(HDR1_BYTE);
      send_byte(HDR1_BYTE);
      // Wrong address byte.
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(8'h02);
      // Length too large for the buffer.
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(ADDR_RESET);
      send_byte(8'd28);
      // Empty payload: the next byte completes the frame with a format error.
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(ADDR_RESET);
      send_byte(8'h00);
      send_byte(ADDR_RESET);
   endtask

   // Mostly well-formed frames with random content, plus broken frames,
   // aborts and noise, until the phase has produced enough real responses.
   task automatic run_traffic(input int target);
      int         kind;
      logic [7:0] len;
      int         pick;
      while (sb.counted < target) begin
         send_calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 88) begin
            send_request(OP_ARM, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 8'hA9)));
         end
         if (kind < 45) begin
            send_frame(GOOD_LENGTH, 1'b0, 1'b0, 1'b0, -1);
         end else if (kind < 58) begin
            send_frame(GOOD_LENGTH, 1'b1, 1'b0, 1'b0, -1);
         end else if (kind < 68) begin
            // Completed frame of a wrong but acceptable length.
            pick = $urandom_range(0, 5);
            case (pick)
               0: len = 8'd0;
               1: len = 8'd15;
               2: len = 8'd17;
               3: len = 8'(FRAME_BUFFER - 5);
               default: len = 8'($urandom_range(0, FRAME_BUFFER - 5));
            endcase
            if (len == GOOD_LENGTH)
               len = 8'd1;
            send_frame(len, 1'($urandom), 1'b0, 1'b0, -1);
         end else if (kind < 73) begin
            // Oversized length, up to three trailing bytes, then an abort.
            len = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(FRAME_BUFFER - 4, 255));
            send_frame(len, 1'b0, 1'b0, 1'b0, 4 + $urandom_range(0, 3));
         end else if (kind < 80) begin
            // Broken header, then a good frame that must still be found.
            if ($urandom_range(0, 1) == 0)
               send_frame(GOOD_LENGTH, 1'b0, 1'b1, 1'b0, 2 + $urandom_range(0, 1));
            else
               send_frame(GOOD_LENGTH, 1'b0, 1'b0, 1'b1, 3 + $urandom_range(0, 1));
            send_request(OP_ARM, 8'($urandom));
            send_frame(GOOD_LENGTH, 1'b0, 1'b0, 1'b0, -1);
         end else if (kind < 88) begin
            send_frame(GOOD_LENGTH, 1'b0, 1'b0, 1'b0, $urandom_range(1, 20));
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(op_type'($urandom_range(0, 3)), 8'($urandom));
         end
         if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom));
      end
   endtask

   // Main sequence: reset, directed checks, then random traffic under
   // several device addresses.
   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      req_tvalid  = 1'b0;
      req_tuser   = OP_NONE;
      req_tdata   = 8'h00;
      send_calm   = 1'b0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_traffic(sb.counted + PHASE_ITEMS / 2);
      write_address(8'h00);
      run_traffic(sb.counted + PHASE_ITEMS);
      write_address(8'hFF);
      run_traffic(sb.counted + PHASE_ITEMS);
      write_address(8'($urandom_range(2, 254)));
      run_traffic(sb.counted + PHASE_ITEMS);
      write_address(ADDR_RESET);
      run_traffic(sb.counted + PHASE_ITEMS / 2);

      // Drain the remaining responses and allow for stray extras.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
